### hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check that a property holds at every clock edge outside reset.
`define ASSERT_HOLDS(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Check that an expression is never true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ASSERT_HOLDS(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, expr, msg)
`endif
`endif

### hw/rtl/lfu_pkg.sv
// Constants and widths for the LFU cache.
package lfu_pkg;
  localparam int CAP       = 16;
  localparam int IDX_W     = $clog2(CAP);
  localparam int CAP_W     = $clog2(CAP + 1);
  localparam int KEY_W     = 32;
  localparam int VAL_W     = 32;
  localparam int CNT_W     = 31;
  localparam int STAMP_W   = 48;
  localparam int CFG_W     = 5;

  localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};
  localparam logic [CFG_W-1:0] CAP_RESET = CFG_W'(16);

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;
endpackage

### hw/rtl/lfu_cache.sv
// LFU cache with LRU tie-break: scan sequencer, entry store and result register.
//
// Usage: raise start with command, lookup_key and store_value; the request is
// transferred at a clock edge where start is high and busy is low. busy then
// stays high while the block walks all CAP entries, one per cycle, through a
// single compare unit that tracks the key match, the first free slot and the
// eviction victim (lowest use count, then largest age). The S_DONE state
// writes the chosen entry; a new request is taken only once the block is idle
// again. A get produces one result: done pulses for one cycle, registered in
// S_DONE together with the write-back, with hit and read_value (all ones on a
// miss). A put produces no result. The receiver cannot stall; the result is
// valid for that one cycle.
// capacity is written through cfg_we/cfg_wdata; the user must write it only while
// the block is idle, which the block does not enforce. Values above CAP act as CAP and zero disables puts.
// Reset (rst, synchronous) marks every entry invalid, clears occupancy and the
// operation clock, sets capacity to 16 and returns the sequencer to idle.
`include "assert_macros.svh"
module lfu_cache (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic                              command,
  input  logic        [lfu_pkg::KEY_W-1:0]  lookup_key,
  input  logic signed [lfu_pkg::VAL_W-1:0]  store_value,
  input  logic                              cfg_we,
  input  logic        [lfu_pkg::CFG_W-1:0]  cfg_wdata,
  output logic                              done,
  output logic                              hit,
  output logic signed [lfu_pkg::VAL_W-1:0]  read_value
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  // Entry store
  logic                          entry_valid [lfu_pkg::CAP];
  logic [lfu_pkg::KEY_W-1:0]     entry_key   [lfu_pkg::CAP];
  logic [lfu_pkg::VAL_W-1:0]     entry_value [lfu_pkg::CAP];
  logic [lfu_pkg::CNT_W-1:0]     entry_count [lfu_pkg::CAP];
  logic [lfu_pkg::STAMP_W-1:0]   entry_stamp [lfu_pkg::CAP];

  logic [1:0]                    state;
  logic [lfu_pkg::IDX_W-1:0]     scan_idx;
  logic [lfu_pkg::CFG_W-1:0]     capacity;
  logic [lfu_pkg::CAP_W-1:0]     occupancy;
  logic [lfu_pkg::STAMP_W-1:0]   op_clock;

  // Latched request
  logic                          req_cmd;
  logic [lfu_pkg::KEY_W-1:0]     req_key;
  logic [lfu_pkg::VAL_W-1:0]     req_value;

  // Scan trackers
  logic                          mt_found;
  logic [lfu_pkg::IDX_W-1:0]     mt_idx;
  logic [lfu_pkg::VAL_W-1:0]     mt_value;
  logic [lfu_pkg::CNT_W-1:0]     mt_count;
  logic                          fr_found;
  logic [lfu_pkg::IDX_W-1:0]     fr_idx;
  logic                          vic_found;
  logic [lfu_pkg::IDX_W-1:0]     vic_idx;
  logic [lfu_pkg::CNT_W-1:0]     vic_count;
  logic [lfu_pkg::STAMP_W-1:0]   vic_age;

  logic                          accept;
  logic                          cur_valid;
  logic [lfu_pkg::KEY_W-1:0]     cur_key;
  logic [lfu_pkg::VAL_W-1:0]     cur_value;
  logic [lfu_pkg::CNT_W-1:0]     cur_count;
  logic [lfu_pkg::STAMP_W-1:0]   cur_age;
  logic                          cur_match;
  logic                          cur_better;

  logic [lfu_pkg::CAP_W-1:0]     cap_eff;
  logic                          use_free;
  logic                          do_touch;
  logic                          do_insert;
  logic [lfu_pkg::IDX_W-1:0]     ins_idx;
  logic [lfu_pkg::CNT_W-1:0]     mt_count_inc;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // Read the entry under the scan pointer and compare it
  always_comb begin
    cur_valid  = entry_valid[scan_idx];
    cur_key    = entry_key[scan_idx];
    cur_value  = entry_value[scan_idx];
    cur_count  = entry_count[scan_idx];
    cur_age    = op_clock - entry_stamp[scan_idx];
    cur_match  = cur_valid && (cur_key == req_key);
    cur_better = cur_valid && (!vic_found || (cur_count < vic_count) ||
                 ((cur_count == vic_count) && (cur_age > vic_age)));
  end

  // Decide the write-back
  always_comb begin
    cap_eff      = (capacity > lfu_pkg::CFG_W'(lfu_pkg::CAP)) ?
                   lfu_pkg::CAP_W'(lfu_pkg::CAP) : lfu_pkg::CAP_W'(capacity);
    use_free     = fr_found && (occupancy < cap_eff);
    mt_count_inc = (mt_count == lfu_pkg::CNT_MAX) ? mt_count
                                                  : mt_count + lfu_pkg::CNT_W'(1);
    do_touch     = mt_found &&
                   ((req_cmd == lfu_pkg::CMD_GET) || (cap_eff != '0));
    do_insert    = (req_cmd == lfu_pkg::CMD_PUT) && (cap_eff != '0) && !mt_found &&
                   (use_free || vic_found);
    ins_idx      = use_free ? fr_idx : vic_idx;
  end

  // Sequencer, control registers and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      scan_idx  <= '0;
      capacity  <= lfu_pkg::CAP_RESET;
      occupancy <= '0;
      op_clock  <= '0;
      done      <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            state    <= S_SCAN;
            scan_idx <= '0;
            op_clock <= op_clock + lfu_pkg::STAMP_W'(1);
          end
        end
        S_SCAN: begin
          scan_idx <= scan_idx + lfu_pkg::IDX_W'(1);
          if (scan_idx == lfu_pkg::IDX_W'(lfu_pkg::CAP - 1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          state <= S_IDLE;
          if (do_insert && use_free) begin
            occupancy <= occupancy + lfu_pkg::CAP_W'(1);
          end
          if (req_cmd == lfu_pkg::CMD_GET) begin
            done <= 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Latch the request, track match, free slot and victim, register the result
  always_ff @(posedge clk) begin
    if (accept) begin
      req_cmd   <= command;
      req_key   <= lookup_key;
      req_value <= store_value;
      mt_found  <= 1'b0;
      fr_found  <= 1'b0;
      vic_found <= 1'b0;
    end else if (state == S_SCAN) begin
      if (cur_match && !mt_found) begin
        mt_found <= 1'b1;
        mt_idx   <= scan_idx;
        mt_value <= cur_value;
        mt_count <= cur_count;
      end
      if (!cur_valid && !fr_found) begin
        fr_found <= 1'b1;
        fr_idx   <= scan_idx;
      end
      if (cur_better) begin
        vic_found <= 1'b1;
        vic_idx   <= scan_idx;
        vic_count <= cur_count;
        vic_age   <= cur_age;
      end
    end
    if (state == S_DONE) begin
      hit        <= mt_found;
      read_value <= mt_found ? mt_value : {lfu_pkg::VAL_W{1'b1}};
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < lfu_pkg::CAP; i++) begin
        entry_valid[i] <= 1'b0;
      end
    end else if ((state == S_DONE) && do_insert) begin
      entry_valid[ins_idx] <= 1'b1;
    end
  end

  // Entry payload write-back
  always_ff @(posedge clk) begin
    if (state == S_DONE) begin
      if (do_touch) begin
        entry_count[mt_idx] <= mt_count_inc;
        entry_stamp[mt_idx] <= op_clock;
        if (req_cmd == lfu_pkg::CMD_PUT) begin
          entry_value[mt_idx] <= req_value;
        end
      end else if (do_insert) begin
        entry_key[ins_idx]   <= req_key;
        entry_value[ins_idx] <= req_value;
        entry_count[ins_idx] <= lfu_pkg::CNT_W'(1);
        entry_stamp[ins_idx] <= op_clock;
      end
    end
  end

  // Checks
  `ASSERT_HOLDS(a_done_idle, clk, rst, done |-> !busy, "result shown while busy")
  `ASSERT_NEVER(a_occ_range, clk, rst, occupancy > lfu_pkg::CAP_W'(lfu_pkg::CAP), "occupancy above CAP")
  `ASSERT_HOLDS(a_start_scan, clk, rst, accept |=> (state == S_SCAN) && (scan_idx == '0), "scan did not start")
  `ASSERT_HOLDS(a_done_get, clk, rst, done |-> ($past(state) == S_DONE) && (req_cmd == lfu_pkg::CMD_GET), "stray result")

endmodule
